### src/crc32c_stream_engine_defines.svh
// Assertion macros used by the CRC-32C stream engine checker.
`ifndef CRC32C_STREAM_ENGINE_DEFINES_SVH
`define CRC32C_STREAM_ENGINE_DEFINES_SVH

// Checked only while out of reset.
`define CRC32C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRC32C_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/crc32c_pkg.sv
// Types, constants and constant GF(2) matrix helpers for the CRC-32C engine.
package crc32c_pkg;

  // Reflected Castagnoli polynomial
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;

  // Bytes carried by the data field, and the index width that selects one
  localparam int unsigned DATA_BYTES = 8;
  localparam int unsigned BYTE_IDX_W = 3;

  typedef logic [31:0] crc_word_t;

  // Linear map on the remainder: column b is the image of bit b
  typedef logic [31:0][31:0] crc_mat_t;

  // Start-of-message control carried down the pipeline
  typedef struct packed {
    logic      first;
    crc_word_t seed;
  } crc_start_t;

  // Bitwise fold over nbytes whole bytes; used to build constant matrices only
  function automatic crc_word_t crc_advance(crc_word_t r, int unsigned nbytes);
    crc_word_t acc;
    acc = r;
    for (int unsigned i = 0; i < nbytes * 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  // Matrix of folding nbytes zero bytes through the remainder
  function automatic crc_mat_t crc_fold_mat(int unsigned nbytes);
    crc_mat_t m;
    for (int unsigned b = 0; b < 32; b++) begin
      m[b] = crc_advance(crc_word_t'(1) << b, nbytes);
    end
    return m;
  endfunction

  // Apply a constant matrix: XOR of the columns picked by the set bits
  function automatic crc_word_t crc_mat_apply(crc_mat_t m, crc_word_t v);
    crc_word_t acc;
    acc = '0;
    for (int unsigned b = 0; b < 32; b++) begin
      if (v[b]) begin
        acc = acc ^ m[b];
      end
    end
    return acc;
  endfunction

endpackage

### src/crc32c_lane.sv
// One byte lane: picks its right-aligned byte and maps it to a remainder term.
module crc32c_lane import crc32c_pkg::*; #(
  parameter int unsigned LANE_BYTES = 8,
  parameter int unsigned LANE       = 0,
  parameter int unsigned CNT_W      = 4
) (
  input  logic [63:0]      data,
  input  logic [CNT_W-1:0] count,
  output crc_word_t        contrib
);

  // Byte in this lane is folded, then followed by the lanes above it
  localparam crc_mat_t BYTE_MAT = crc_fold_mat(LANE_BYTES - LANE);

  logic [7:0] data_bytes [DATA_BYTES];
  logic [5:0] pos_sum;
  logic [5:0] pos_idx;
  logic [7:0] lane_byte;

  // Bytes are right-aligned so the last valid byte sits in the top lane;
  // leading zero bytes leave a zero remainder untouched
  always_comb begin
    for (int unsigned i = 0; i < DATA_BYTES; i++) begin
      data_bytes[i] = data[8*i +: 8];
    end
    pos_sum = 6'(LANE) + 6'(count);
    pos_idx = pos_sum - 6'(LANE_BYTES);
    if (pos_sum >= 6'(LANE_BYTES) && pos_idx < 6'(DATA_BYTES)) begin
      lane_byte = data_bytes[pos_idx[BYTE_IDX_W-1:0]];
    end else begin
      lane_byte = 8'h00;
    end
  end

  assign contrib = crc_mat_apply(BYTE_MAT, {24'h000000, lane_byte});

endmodule

### src/crc32c_merge.sv
// Merge stage: advances the remainder by the byte count and XORs in the lanes.
module crc32c_merge import crc32c_pkg::*; #(
  parameter int unsigned LANE_BYTES = 8,
  parameter int unsigned CNT_W      = 4
) (
  input  crc_word_t                   rem,
  input  crc_start_t                  start,
  input  logic [CNT_W-1:0]            count,
  input  logic [LANE_BYTES-1:0][31:0] lane_crc,
  output crc_word_t                   next_rem
);

  crc_word_t base;
  crc_word_t shifted [LANE_BYTES+1];
  crc_word_t lane_sum;

  // A first transaction restarts from the inverted seed
  assign base = start.first ? ~start.seed : rem;

  // One constant advance per possible byte count
  for (genvar g = 0; g <= LANE_BYTES; g++) begin : g_adv
    localparam crc_mat_t ADV_MAT = crc_fold_mat(g);
    assign shifted[g] = crc_mat_apply(ADV_MAT, base);
  end

  // Combine lane terms
  always_comb begin
    lane_sum = '0;
    for (int unsigned i = 0; i < LANE_BYTES; i++) begin
      lane_sum = lane_sum ^ lane_crc[i];
    end
  end

  assign next_rem = shifted[count] ^ lane_sum;

endmodule

### src/crc32c_stream_engine.sv
// Top level of the CRC-32C stream engine: lane stage, merge stage, output register.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | data, byte_count, first, seed
//  out_    | output    | out_valid/out_stall | crc_value
//
// One transaction per cycle while the output is not stalled; the lane stage
// register holds an input and the output register its result. The rate is set
// by the remainder feedback, which the merge stage advances by 0..LANE_BYTES bytes.
// Synchronous active-low reset empties both stages and sets the remainder to
// all ones. A stalled output holds its result; the lane stage still takes one
// more transaction and input stall rises only when both stages are full.
module crc32c_stream_engine import crc32c_pkg::*; #(
  parameter int unsigned LANE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first,
  input  logic [31:0] in_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_value
);

  localparam int unsigned CNT_W = $clog2(LANE_BYTES + 1);

  logic                        advance;
  logic                        in_acc;
  logic [CNT_W-1:0]            count_sat;
  logic [LANE_BYTES-1:0][31:0] lane_crc;
  crc_word_t                   rem_nxt;

  logic                        s1_valid_r;
  logic [LANE_BYTES-1:0][31:0] s1_lane_r;
  logic [CNT_W-1:0]            s1_count_r;
  crc_start_t                  s1_start_r;
  crc_word_t                   rem_r;
  logic                        out_valid_r;
  crc_word_t                   out_crc_r;

  // Handshake: the output register drains or is empty
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  // Counts above the lane width saturate
  always_comb begin
    if ({1'b0, in_byte_count} > 5'(LANE_BYTES)) begin
      count_sat = CNT_W'(LANE_BYTES);
    end else begin
      count_sat = CNT_W'(in_byte_count);
    end
  end

  // Byte lanes
  for (genvar j = 0; j < LANE_BYTES; j++) begin : g_lane
    crc32c_lane #(
      .LANE_BYTES (LANE_BYTES),
      .LANE       (j),
      .CNT_W      (CNT_W)
    ) u_lane (
      .data    (in_data),
      .count   (count_sat),
      .contrib (lane_crc[j])
    );
  end

  // Merge with the running remainder
  crc32c_merge #(
    .LANE_BYTES (LANE_BYTES),
    .CNT_W      (CNT_W)
  ) u_merge (
    .rem      (rem_r),
    .start    (s1_start_r),
    .count    (s1_count_r),
    .lane_crc (s1_lane_r),
    .next_rem (rem_nxt)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= '1;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          rem_r <= rem_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_lane_r        <= lane_crc;
      s1_count_r       <= count_sat;
      s1_start_r.first <= in_first;
      s1_start_r.seed  <= in_seed;
    end
    if (advance && s1_valid_r) begin
      out_crc_r <= ~rem_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

### src/crc32c_checker.sv
// Port-level checker for the CRC-32C stream engine, bound to the top level.
`include "crc32c_stream_engine_defines.svh"

module crc32c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [3:0]  in_byte_count,
  input logic        in_first,
  input logic [31:0] in_seed,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_crc_value
);

  // A stalled result holds
  `CRC32C_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_crc_value),
    "stalled result changed")

  // Input stalls only behind a full, stalled output
  `CRC32C_ASSERT(a_stall_cause,
    in_stall |-> out_valid && out_stall,
    "input stalled without output back-pressure")

  // Reset empties the pipeline
  `CRC32C_ASSERT_RST(a_reset_empty,
    !rst_n |=> !out_valid && !in_stall,
    "pipeline not empty after reset")

  // A fresh message with no bytes returns its seed
  `CRC32C_ASSERT(a_seed_echo,
    in_valid && !in_stall && in_first && in_byte_count == 4'd0 ##1 !out_stall
      |=> out_valid && out_crc_value == $past(in_seed, 2),
    "empty first transaction did not echo seed")

endmodule

bind crc32c_stream_engine crc32c_checker u_crc32c_checker (.*);
